FILE: sv/exti_pkg.sv
// Shared constants, opcode codes and types for the external interrupt line controller.
// Used by exti_lane, exti_merge and external_interrupt_line_controller_top.
package exti_pkg;

  localparam int FIELD_W = 20;
  localparam int LINE_COUNT = 20;
  localparam int IRQ_W = 7;
  localparam int GROUP_LINE_W = 4;

  // Lines at or above LINE_COUNT are held at zero everywhere.
  localparam logic [FIELD_W-1:0] LINE_MASK =
    (LINE_COUNT >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << LINE_COUNT) - 64'd1);

  localparam int SOLO_LINES = 5;
  localparam int MID_LOW = 5;
  localparam int MID_HIGH = 9;
  localparam int UP_LOW = 10;
  localparam int UP_HIGH = 15;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_TRIGGER = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [1:0] REG_INTERRUPT_MASK = 2'd0;
  localparam logic [1:0] REG_EVENT_MASK = 2'd1;
  localparam logic [1:0] REG_RISING_SELECT = 2'd2;
  localparam logic [1:0] REG_FALLING_SELECT = 2'd3;

  typedef struct packed {
    logic       accept;
    logic [1:0] opcode;
  } lane_ctrl_t;

endpackage

FILE: sv/exti_lane.sv
// One interrupt line: edge detection, pending bit and event pulse.
// Depends on exti_pkg for the opcode codes and the lane control struct.
module exti_lane (
  input  logic                clk,
  input  logic                rst,
  input  exti_pkg::lane_ctrl_t ctrl,
  input  logic                level,
  input  logic                sel,
  input  logic                rise_en,
  input  logic                fall_en,
  input  logic                evt_en,
  output logic                pend_next,
  output logic                evt
);

  logic prev_level;
  logic pend;
  logic trig;
  logic pend_kept;

  always_comb begin
    trig = 1'b0;
    pend_kept = pend;
    case (ctrl.opcode)
      exti_pkg::OP_TICK: begin
        trig = (level & ~prev_level & rise_en) | (~level & prev_level & fall_en);
      end
      exti_pkg::OP_CLEAR: begin
        pend_kept = pend & ~sel;
      end
      exti_pkg::OP_TRIGGER: begin
        trig = sel;
      end
      default: begin
        trig = 1'b0;
      end
    endcase
    pend_next = pend_kept | trig;
    evt = trig & evt_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      pend <= 1'b0;
    end else if (ctrl.accept) begin
      pend <= pend_next;
      if (ctrl.opcode == exti_pkg::OP_TICK) begin
        prev_level <= level;
      end
    end
  end

endmodule

FILE: sv/exti_merge.sv
// Merging stage: masks pending bits, finds the lowest active line of each shared
// group and registers the result word. Depends on exti_pkg.
module exti_merge (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic                                 take,
  input  logic [exti_pkg::FIELD_W-1:0]         pend_next,
  input  logic [exti_pkg::FIELD_W-1:0]         evt,
  input  logic [exti_pkg::FIELD_W-1:0]         interrupt_mask,
  output logic                                 res_valid,
  output logic [exti_pkg::FIELD_W-1:0]         pending_view,
  output logic [exti_pkg::IRQ_W-1:0]           irq_requests,
  output logic [exti_pkg::FIELD_W-1:0]         event_pulses,
  output logic [exti_pkg::GROUP_LINE_W-1:0]    middle_group_line,
  output logic                                 middle_group_found,
  output logic [exti_pkg::GROUP_LINE_W-1:0]    upper_group_line,
  output logic                                 upper_group_found
);

  logic [exti_pkg::FIELD_W-1:0]      active;
  logic [exti_pkg::GROUP_LINE_W-1:0] mid_line;
  logic                              mid_found;
  logic [exti_pkg::GROUP_LINE_W-1:0] up_line;
  logic                              up_found;

  // Scanning downward lets the lowest active line win.
  always_comb begin
    active = pend_next & interrupt_mask;
    mid_line = '0;
    mid_found = 1'b0;
    for (int b = exti_pkg::MID_HIGH; b >= exti_pkg::MID_LOW; b--) begin
      if (active[b]) begin
        mid_line = exti_pkg::GROUP_LINE_W'(b);
        mid_found = 1'b1;
      end
    end
    up_line = '0;
    up_found = 1'b0;
    for (int b = exti_pkg::UP_HIGH; b >= exti_pkg::UP_LOW; b--) begin
      if (active[b]) begin
        up_line = exti_pkg::GROUP_LINE_W'(b);
        up_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pending_view <= pend_next;
      irq_requests <= {up_found, mid_found, active[exti_pkg::SOLO_LINES-1:0]};
      event_pulses <= evt;
      middle_group_line <= mid_line;
      middle_group_found <= mid_found;
      upper_group_line <= up_line;
      upper_group_found <= up_found;
    end
  end

endmodule

FILE: sv/external_interrupt_line_controller_top.sv
// External interrupt line controller: an accepted word's result is valid in the next
// cycle, one word per cycle as long as results are taken. The result register frees
// in the same cycle it is taken, so input ready is high unless a result waits unread.
// Synchronous active-high reset clears the configuration registers, previous levels,
// pending bits and the result valid flag.
// Depends on exti_pkg, exti_lane and exti_merge.
module external_interrupt_line_controller_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [exti_pkg::FIELD_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic [exti_pkg::FIELD_W-1:0]      line_levels,
  input  logic [exti_pkg::FIELD_W-1:0]      write_mask,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [exti_pkg::FIELD_W-1:0]      pending_view,
  output logic [exti_pkg::IRQ_W-1:0]        irq_requests,
  output logic [exti_pkg::FIELD_W-1:0]      event_pulses,
  output logic [exti_pkg::GROUP_LINE_W-1:0] middle_group_line,
  output logic                              middle_group_found,
  output logic [exti_pkg::GROUP_LINE_W-1:0] upper_group_line,
  output logic                              upper_group_found
);

  logic [exti_pkg::FIELD_W-1:0] interrupt_mask;
  logic [exti_pkg::FIELD_W-1:0] event_mask;
  logic [exti_pkg::FIELD_W-1:0] rising_select;
  logic [exti_pkg::FIELD_W-1:0] falling_select;
  logic [exti_pkg::FIELD_W-1:0] levels;
  logic [exti_pkg::FIELD_W-1:0] sel;
  logic [exti_pkg::FIELD_W-1:0] pend_next;
  logic [exti_pkg::FIELD_W-1:0] evt;
  logic                         accept;
  exti_pkg::lane_ctrl_t         ctrl;

  assign in_ready = ~out_valid | out_ready;
  assign accept = in_valid & in_ready;
  assign ctrl.accept = accept;
  assign ctrl.opcode = opcode;
  assign levels = line_levels & exti_pkg::LINE_MASK;
  assign sel = write_mask & exti_pkg::LINE_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      interrupt_mask <= '0;
      event_mask <= '0;
      rising_select <= '0;
      falling_select <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        exti_pkg::REG_INTERRUPT_MASK: interrupt_mask <= cfg_data & exti_pkg::LINE_MASK;
        exti_pkg::REG_EVENT_MASK:     event_mask <= cfg_data & exti_pkg::LINE_MASK;
        exti_pkg::REG_RISING_SELECT:  rising_select <= cfg_data & exti_pkg::LINE_MASK;
        exti_pkg::REG_FALLING_SELECT: falling_select <= cfg_data & exti_pkg::LINE_MASK;
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < exti_pkg::FIELD_W; i++) begin : g_lane
    exti_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .level    (levels[i]),
      .sel      (sel[i]),
      .rise_en  (rising_select[i]),
      .fall_en  (falling_select[i]),
      .evt_en   (event_mask[i]),
      .pend_next(pend_next[i]),
      .evt      (evt[i])
    );
  end

  exti_merge u_merge (
    .clk               (clk),
    .rst               (rst),
    .load              (accept),
    .take              (out_ready),
    .pend_next         (pend_next),
    .evt               (evt),
    .interrupt_mask    (interrupt_mask),
    .res_valid         (out_valid),
    .pending_view      (pending_view),
    .irq_requests      (irq_requests),
    .event_pulses      (event_pulses),
    .middle_group_line (middle_group_line),
    .middle_group_found(middle_group_found),
    .upper_group_line  (upper_group_line),
    .upper_group_found (upper_group_found)
  );

endmodule

FILE: test/external_interrupt_line_controller_top_tb.sv
// Self-checking testbench for external_interrupt_line_controller_top: line sampling, pending
// clear, software trigger and pending read words checked against a line status predictor.
// Depends on exti_pkg and the controller RTL; needs no files or arguments.
module external_interrupt_line_controller_top_tb;

  localparam int IDLE_LIMIT = 3000;
  localparam logic [exti_pkg::FIELD_W-1:0] ALL_LINES = {exti_pkg::FIELD_W{1'b1}};

  typedef struct packed {
    logic [1:0]                   opcode;
    logic [exti_pkg::FIELD_W-1:0] line_levels;
    logic [exti_pkg::FIELD_W-1:0] write_mask;
  } bus_word_t;

  typedef struct packed {
    logic [exti_pkg::FIELD_W-1:0]      pending_view;
    logic [exti_pkg::IRQ_W-1:0]        irq_requests;
    logic [exti_pkg::FIELD_W-1:0]      event_pulses;
    logic [exti_pkg::GROUP_LINE_W-1:0] middle_group_line;
    logic                              middle_group_found;
    logic [exti_pkg::GROUP_LINE_W-1:0] upper_group_line;
    logic                              upper_group_found;
  } line_status_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_we;
  logic [1:0]                        cfg_index;
  logic [exti_pkg::FIELD_W-1:0]      cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic [1:0]                        opcode;
  logic [exti_pkg::FIELD_W-1:0]      line_levels;
  logic [exti_pkg::FIELD_W-1:0]      write_mask;
  logic                              out_valid;
  logic                              out_ready;
  logic [exti_pkg::FIELD_W-1:0]      pending_view;
  logic [exti_pkg::IRQ_W-1:0]        irq_requests;
  logic [exti_pkg::FIELD_W-1:0]      event_pulses;
  logic [exti_pkg::GROUP_LINE_W-1:0] middle_group_line;
  logic                              middle_group_found;
  logic [exti_pkg::GROUP_LINE_W-1:0] upper_group_line;
  logic                              upper_group_found;

  bus_word_t    queued_words[$];
  line_status_t expected_status[$];

  // Shadow copies of the registers and the line state.
  logic [exti_pkg::FIELD_W-1:0] shadow_irq_mask, shadow_event_mask;
  logic [exti_pkg::FIELD_W-1:0] shadow_rise_sel, shadow_fall_sel;
  logic [exti_pkg::FIELD_W-1:0] track_levels, track_pending;

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  word_taken = 0;
  int  send_gap = 0, send_calm = 0, recv_stall = 0, recv_calm = 0;

  external_interrupt_line_controller_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .line_levels(line_levels), .write_mask(write_mask),
    .out_valid(out_valid), .out_ready(out_ready),
    .pending_view(pending_view), .irq_requests(irq_requests), .event_pulses(event_pulses),
    .middle_group_line(middle_group_line), .middle_group_found(middle_group_found),
    .upper_group_line(upper_group_line), .upper_group_found(upper_group_found)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void lowest_active(input logic [exti_pkg::FIELD_W-1:0] act,
                                        input int lo, input int hi,
                                        output logic [exti_pkg::GROUP_LINE_W-1:0] line,
                                        output logic found);
    line = '0;
    found = 1'b0;
    for (int b = hi; b >= lo; b--) begin
      if (act[b]) begin
        line = exti_pkg::GROUP_LINE_W'(b);
        found = 1'b1;
      end
    end
  endfunction

  // Applies one word to the shadow state and returns the status the block must report.
  function automatic line_status_t compute_line_status(input bus_word_t w);
    line_status_t                 s;
    logic [exti_pkg::FIELD_W-1:0] lv, sel, trig, act;
    lv = w.line_levels & exti_pkg::LINE_MASK;
    sel = w.write_mask & exti_pkg::LINE_MASK;
    trig = '0;
    case (w.opcode)
      exti_pkg::OP_TICK: begin
        trig = ((lv & ~track_levels & shadow_rise_sel) |
                (~lv & track_levels & shadow_fall_sel)) & exti_pkg::LINE_MASK;
        track_levels = lv;
      end
      exti_pkg::OP_CLEAR: track_pending = track_pending & ~sel;
      exti_pkg::OP_TRIGGER: trig = sel;
      default: ;
    endcase
    track_pending = (track_pending | trig) & exti_pkg::LINE_MASK;
    act = track_pending & shadow_irq_mask;
    lowest_active(act, exti_pkg::MID_LOW, exti_pkg::MID_HIGH, s.middle_group_line,
                  s.middle_group_found);
    lowest_active(act, exti_pkg::UP_LOW, exti_pkg::UP_HIGH, s.upper_group_line,
                  s.upper_group_found);
    s.pending_view = track_pending;
    s.irq_requests = {s.upper_group_found, s.middle_group_found,
                      act[exti_pkg::SOLO_LINES-1:0]};
    s.event_pulses = trig & shadow_event_mask;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
  endtask

  // Mostly short gaps, a few long ones, none while a calm stretch lasts.
  function automatic int pick_gap(input int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0 || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Shadow registers follow the write port; words are predicted when accepted.
  always @(posedge clk) begin
    if (rst) begin
      shadow_irq_mask = '0;
      shadow_event_mask = '0;
      shadow_rise_sel = '0;
      shadow_fall_sel = '0;
      track_levels = '0;
      track_pending = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          exti_pkg::REG_INTERRUPT_MASK: shadow_irq_mask = cfg_data & exti_pkg::LINE_MASK;
          exti_pkg::REG_EVENT_MASK: shadow_event_mask = cfg_data & exti_pkg::LINE_MASK;
          exti_pkg::REG_RISING_SELECT: shadow_rise_sel = cfg_data & exti_pkg::LINE_MASK;
          exti_pkg::REG_FALLING_SELECT: shadow_fall_sel = cfg_data & exti_pkg::LINE_MASK;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_status.push_back(compute_line_status({opcode, line_levels, write_mask}));
        word_taken = 1;
      end
    end
  end

  // Input driver: a presented word is held until it is taken.
  always @(negedge clk) begin : word_driver
    bus_word_t w;
    if (!rst) begin
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(0, 199) == 0) send_calm = $urandom_range(40, 150);
      if (!in_valid || word_taken) begin
        word_taken = 0;
        in_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_words.size() != 0) begin
          w = queued_words.pop_front();
          opcode = w.opcode;
          line_levels = w.line_levels;
          write_mask = w.write_mask;
          in_valid = 1'b1;
          send_gap = pick_gap(send_calm);
        end
      end
    end
  end

  // Result side: random back-pressure, then compare each taken word.
  always @(negedge clk) begin
    if (!rst) begin
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 199) == 0) recv_calm = $urandom_range(40, 150);
      if (recv_stall > 0) begin
        out_ready = 1'b0;
        recv_stall--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) recv_stall = pick_gap(recv_calm);
      end
    end
  end

  always @(posedge clk) begin : status_monitor
    line_status_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected result word, pending_view", 32'(pending_view), 32'd0);
      end else begin
        want = expected_status.pop_front();
        if (pending_view !== want.pending_view)
          report_mismatch("pending_view", 32'(pending_view), 32'(want.pending_view));
        if (irq_requests !== want.irq_requests)
          report_mismatch("irq_requests", 32'(irq_requests), 32'(want.irq_requests));
        if (event_pulses !== want.event_pulses)
          report_mismatch("event_pulses", 32'(event_pulses), 32'(want.event_pulses));
        if (middle_group_line !== want.middle_group_line)
          report_mismatch("middle_group_line", 32'(middle_group_line),
                          32'(want.middle_group_line));
        if (middle_group_found !== want.middle_group_found)
          report_mismatch("middle_group_found", 32'(middle_group_found),
                          32'(want.middle_group_found));
        if (upper_group_line !== want.upper_group_line)
          report_mismatch("upper_group_line", 32'(upper_group_line),
                          32'(want.upper_group_line));
        if (upper_group_found !== want.upper_group_found)
          report_mismatch("upper_group_found", 32'(upper_group_found),
                          32'(want.upper_group_found));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_word(input logic [1:0] op, input logic [exti_pkg::FIELD_W-1:0] lv,
                           input logic [exti_pkg::FIELD_W-1:0] wm);
    queued_words.push_back('{opcode: op, line_levels: lv, write_mask: wm});
  endtask

  task automatic wait_idle();
    while (queued_words.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_registers(input logic [exti_pkg::FIELD_W-1:0] irq_m,
                                   input logic [exti_pkg::FIELD_W-1:0] ev_m,
                                   input logic [exti_pkg::FIELD_W-1:0] rise,
                                   input logic [exti_pkg::FIELD_W-1:0] fall);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = exti_pkg::REG_INTERRUPT_MASK;
    cfg_data = irq_m;
    @(negedge clk);
    cfg_index = exti_pkg::REG_EVENT_MASK;
    cfg_data = ev_m;
    @(negedge clk);
    cfg_index = exti_pkg::REG_RISING_SELECT;
    cfg_data = rise;
    @(negedge clk);
    cfg_index = exti_pkg::REG_FALLING_SELECT;
    cfg_data = fall;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [exti_pkg::FIELD_W-1:0] random_register();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ALL_LINES;
      default: return exti_pkg::FIELD_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [exti_pkg::FIELD_W-1:0] gen_levels, lv, wm;
    logic [1:0]                   op;
    int                           r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = exti_pkg::REG_INTERRUPT_MASK;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = exti_pkg::OP_TICK;
    line_levels = '0;
    write_mask = '0;
    out_ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Rising edges everywhere, all lines enabled and event-enabled.
    program_registers(ALL_LINES, ALL_LINES, ALL_LINES, '0);
    push_word(exti_pkg::OP_TICK, '0, ALL_LINES);
    push_word(exti_pkg::OP_TICK, ALL_LINES, '0);
    push_word(exti_pkg::OP_READ, ALL_LINES, ALL_LINES);
    push_word(exti_pkg::OP_CLEAR, '0, ALL_LINES);
    push_word(exti_pkg::OP_TICK, '0, '0);
    push_word(exti_pkg::OP_TRIGGER, ALL_LINES, 20'h00020);
    push_word(exti_pkg::OP_TRIGGER, '0, 20'h08000);
    push_word(exti_pkg::OP_TRIGGER, '0, 20'hF0000);
    push_word(exti_pkg::OP_CLEAR, 20'h5A5A5, 20'h00020);
    push_word(exti_pkg::OP_READ, '0, '0);
    push_word(exti_pkg::OP_CLEAR, '0, ALL_LINES);
    push_word(exti_pkg::OP_TRIGGER, ALL_LINES, '0);
    wait_idle();

    // Falling edges only, alternate lines masked.
    program_registers(20'h0AAAA, 20'h55555, '0, ALL_LINES);
    push_word(exti_pkg::OP_TICK, ALL_LINES, '0);
    push_word(exti_pkg::OP_TICK, '0, ALL_LINES);
    push_word(exti_pkg::OP_READ, ALL_LINES, '0);
    push_word(exti_pkg::OP_CLEAR, ALL_LINES, 20'h003E0);
    push_word(exti_pkg::OP_CLEAR, '0, 20'h0FC00);
    push_word(exti_pkg::OP_TICK, 20'h00400, '0);
    push_word(exti_pkg::OP_TICK, '0, '0);
    push_word(exti_pkg::OP_TRIGGER, '0, 20'h00200);
    push_word(exti_pkg::OP_READ, '0, '0);
    wait_idle();

    gen_levels = '0;
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 0) program_registers(ALL_LINES, ALL_LINES, ALL_LINES, ALL_LINES);
      else if (phase == 1) program_registers('0, '0, '0, '0);
      else program_registers(random_register(), random_register(), random_register(),
                             random_register());
      for (int n = 0; n < 150; n++) begin
        r = $urandom_range(0, 99);
        lv = exti_pkg::FIELD_W'($urandom);
        case ($urandom_range(0, 5))
          0: wm = ALL_LINES;
          1, 2: wm = exti_pkg::FIELD_W'(1) << $urandom_range(0, exti_pkg::FIELD_W - 1);
          default: wm = exti_pkg::FIELD_W'($urandom);
        endcase
        if (r < 55) begin
          // Most samples toggle a line or two so edges stay sparse.
          op = exti_pkg::OP_TICK;
          case ($urandom_range(0, 9))
            0: gen_levels = exti_pkg::FIELD_W'($urandom);
            1: gen_levels = ~gen_levels;
            default: begin
              gen_levels[$urandom_range(0, exti_pkg::FIELD_W - 1)] ^= 1'b1;
              if ($urandom_range(0, 1) == 1)
                gen_levels[$urandom_range(0, exti_pkg::FIELD_W - 1)] ^= 1'b1;
            end
          endcase
          lv = gen_levels;
        end else if (r < 70) begin
          op = exti_pkg::OP_CLEAR;
        end else if (r < 85) begin
          op = exti_pkg::OP_TRIGGER;
        end else begin
          op = exti_pkg::OP_READ;
        end
        push_word(op, lv, wm);
      end
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (expected_status.size() != 0)
      report_mismatch("results never returned", 32'(expected_status.size()), 32'd0);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/exti_pkg.sv
sv/exti_lane.sv
sv/exti_merge.sv
sv/external_interrupt_line_controller_top.sv
test/external_interrupt_line_controller_top_tb.sv
